@@ rtl/core/sfl_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package sfl_pkg;

  // Build-time defaults
  localparam int unsigned BLOCK_SIZE_DEF = 128;

  // Field widths
  localparam int unsigned TIMEOUT_W = 24;
  localparam int unsigned ADDR_W    = 16;
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned ACTION_W  = 2;
  localparam int unsigned KIND_W    = 2;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_W     = 24;

  // Input actions
  localparam logic [ACTION_W-1:0] ACT_BYTE = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_TICK = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_STEP = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_TX    = 2'd0;
  localparam logic [KIND_W-1:0] KIND_WRITE = 2'd1;
  localparam logic [KIND_W-1:0] KIND_JUMP  = 2'd2;

  // Protocol bytes
  localparam logic [BYTE_W-1:0] HEAD_BYTE   = 8'hA5;
  localparam logic [BYTE_W-1:0] CMD_WRITE   = 8'hA7;
  localparam logic [BYTE_W-1:0] CMD_JUMP    = 8'hA9;
  localparam logic [BYTE_W-1:0] REPLY_OK    = 8'hA0;
  localparam logic [BYTE_W-1:0] REPLY_ERR   = 8'hA1;
  localparam logic [BYTE_W-1:0] REPLY_READY = 8'hA4;

  // Configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE    = 1'd1;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RST = 24'd655350;
  localparam logic [ADDR_W-1:0]    BASE_RST    = 16'h8000;

  typedef struct packed {
    logic [TIMEOUT_W-1:0] timeout_ticks;
    logic [ADDR_W-1:0]    flash_base;
  } cfg_t;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [BYTE_W-1:0] tx_byte;
    logic [ADDR_W-1:0] flash_address;
    logic [BYTE_W-1:0] flash_data;
  } result_t;

endpackage

`default_nettype wire

@@ rtl/core/sfl_frame_engine.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sfl_frame_engine #(
  parameter int unsigned BLOCK_SIZE = sfl_pkg::BLOCK_SIZE_DEF
) (
  input  wire                            clk,
  input  wire                            rst,
  input  wire                            in_fire,
  input  wire  [sfl_pkg::ACTION_W-1:0]   in_action,
  input  wire  [sfl_pkg::BYTE_W-1:0]     in_byte,
  input  wire  sfl_pkg::cfg_t            cfg,
  input  wire                            advance,
  output logic                           res_valid,
  output sfl_pkg::result_t               res
);
  import sfl_pkg::*;

  localparam int unsigned IDX_W = $clog2(BLOCK_SIZE);
  localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(BLOCK_SIZE - 1);
  localparam logic [ADDR_W-1:0] BLOCK_MUL = ADDR_W'(BLOCK_SIZE);

  typedef enum logic [7:0] {
    PH_WAIT_HEAD = 8'b0000_0001,
    PH_COMMAND   = 8'b0000_0010,
    PH_PAGE      = 8'b0000_0100,
    PH_DATA      = 8'b0000_1000,
    PH_CHECK     = 8'b0001_0000,
    PH_WRITE     = 8'b0010_0000,
    PH_VERIFY    = 8'b0100_0000,
    PH_HALTED    = 8'b1000_0000
  } phase_t;

  phase_t               phase, phase_next;
  logic [TIMEOUT_W-1:0] wait_counter, wait_counter_next, wait_inc;
  logic [ADDR_W-1:0]    page_address, page_address_next;
  logic [IDX_W-1:0]     byte_index, byte_index_next;
  logic [BYTE_W-1:0]    running_sum, running_sum_next, sum_dec;
  logic                 is_last;

  // Page buffer, single synchronous port per direction
  logic [BYTE_W-1:0]    page_buffer [BLOCK_SIZE];
  logic                 mem_we, mem_re;
  logic [BYTE_W-1:0]    mem_rdata;

  // Result produced by the current beat
  logic                 emit;
  logic [KIND_W-1:0]    emit_kind;
  logic [BYTE_W-1:0]    emit_tx;
  logic [ADDR_W-1:0]    emit_addr;
  logic                 emit_mem;

  // Result stage, waits for buffer read data
  logic                 s1_valid;
  logic [KIND_W-1:0]    s1_kind;
  logic [BYTE_W-1:0]    s1_tx;
  logic [ADDR_W-1:0]    s1_addr;
  logic                 s1_mem;

  assign wait_inc = (wait_counter != '1) ? wait_counter + TIMEOUT_W'(1) : wait_counter;
  assign is_last  = (byte_index == LAST_IDX);
  assign sum_dec  = running_sum - in_byte;

  // Frame state machine
  always_comb begin
    phase_next        = phase;
    wait_counter_next = wait_counter;
    page_address_next = page_address;
    byte_index_next   = byte_index;
    running_sum_next  = running_sum;
    mem_we            = 1'b0;
    mem_re            = 1'b0;
    emit              = 1'b0;
    emit_kind         = KIND_TX;
    emit_tx           = '0;
    emit_addr         = '0;
    emit_mem          = 1'b0;
    if (in_fire) begin
      unique case (phase)
        PH_WAIT_HEAD: begin
          if (in_action == ACT_BYTE && in_byte == HEAD_BYTE) begin
            phase_next = PH_COMMAND;
            emit       = 1'b1;
            emit_tx    = REPLY_READY;
          end else if (in_action == ACT_TICK) begin
            wait_counter_next = wait_inc;
            // a zero timeout still fires on the first tick
            if (wait_inc >= cfg.timeout_ticks) begin
              phase_next = PH_HALTED;
              emit       = 1'b1;
              emit_kind  = KIND_JUMP;
            end
          end
        end
        PH_COMMAND: begin
          if (in_action == ACT_BYTE) begin
            if (in_byte == CMD_JUMP) begin
              phase_next = PH_HALTED;
              emit       = 1'b1;
              emit_kind  = KIND_JUMP;
            end else if (in_byte == CMD_WRITE) begin
              phase_next = PH_PAGE;
            end else begin
              emit    = 1'b1;
              emit_tx = REPLY_ERR;
            end
          end
        end
        PH_PAGE: begin
          if (in_action == ACT_BYTE) begin
            page_address_next = cfg.flash_base + ADDR_W'(in_byte) * BLOCK_MUL;
            running_sum_next  = '0;
            byte_index_next   = '0;
            phase_next        = PH_DATA;
          end
        end
        PH_DATA: begin
          if (in_action == ACT_BYTE) begin
            mem_we           = 1'b1;
            running_sum_next = running_sum + in_byte;
            if (is_last) begin
              byte_index_next = '0;
              phase_next      = PH_CHECK;
            end else begin
              byte_index_next = byte_index + IDX_W'(1);
            end
          end
        end
        PH_CHECK: begin
          if (in_action == ACT_BYTE) begin
            if (in_byte == running_sum) begin
              byte_index_next = '0;
              phase_next      = PH_WRITE;
            end else begin
              phase_next = PH_COMMAND;
              emit       = 1'b1;
              emit_tx    = REPLY_ERR;
            end
          end
        end
        PH_WRITE: begin
          if (in_action == ACT_STEP) begin
            mem_re    = 1'b1;
            emit      = 1'b1;
            emit_kind = KIND_WRITE;
            emit_addr = page_address + ADDR_W'(byte_index);
            emit_mem  = 1'b1;
            if (is_last) begin
              byte_index_next = '0;
              phase_next      = PH_VERIFY;
            end else begin
              byte_index_next = byte_index + IDX_W'(1);
            end
          end
        end
        PH_VERIFY: begin
          if (in_action == ACT_STEP) begin
            running_sum_next = sum_dec;
            if (is_last) begin
              byte_index_next = '0;
              phase_next      = PH_COMMAND;
              emit            = 1'b1;
              emit_tx         = (sum_dec == '0) ? REPLY_OK : REPLY_ERR;
            end else begin
              byte_index_next = byte_index + IDX_W'(1);
            end
          end
        end
        PH_HALTED: begin
          // stays here until reset
        end
        default: begin
          phase_next = PH_WAIT_HEAD;
        end
      endcase
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (rst) begin
      phase        <= PH_WAIT_HEAD;
      wait_counter <= '0;
      page_address <= '0;
      byte_index   <= '0;
      running_sum  <= '0;
    end else begin
      phase        <= phase_next;
      wait_counter <= wait_counter_next;
      page_address <= page_address_next;
      byte_index   <= byte_index_next;
      running_sum  <= running_sum_next;
    end
  end

  // Buffer: filled in the data phase, read back strictly later in the
  // write phase, so no same-entry overlap to forward
  always_ff @(posedge clk) begin
    if (mem_we) begin
      page_buffer[byte_index] <= in_byte;
    end
  end

  // read data only moves on a write-step beat, so it holds while s1 stalls
  always_ff @(posedge clk) begin
    if (mem_re) begin
      mem_rdata <= page_buffer[byte_index];
    end
  end

  // Result stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= emit;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  // Result stage payload
  always_ff @(posedge clk) begin
    if (in_fire && emit) begin
      s1_kind <= emit_kind;
      s1_tx   <= emit_tx;
      s1_addr <= emit_addr;
      s1_mem  <= emit_mem;
    end
  end

  assign res_valid         = s1_valid;
  assign res.kind          = s1_kind;
  assign res.tx_byte       = s1_tx;
  assign res.flash_address = s1_addr;
  assign res.flash_data    = s1_mem ? mem_rdata : '0;

endmodule

`default_nettype wire

@@ rtl/core/serial_flash_loader_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Serial boot-loader frame engine. Takes one beat per clock while
// s_axis_tready is high: a received byte, a timer tick or a flash step, and
// answers with at most one result beat (transmit byte, flash write, or jump
// to application). Sustained rate is one input beat per cycle when the output
// is not stalled. A result passes through the result stage, which waits for
// the page buffer RAM read that supplies the flash write data, and then the
// output register. The page buffer is a plain RAM with no clearing pass after
// reset; it is always written before read. Configuration writes are taken at
// any time but must only be issued while the engine is idle.

module serial_flash_loader_core #(
  parameter int unsigned BLOCK_SIZE = sfl_pkg::BLOCK_SIZE_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  // slave side
  input  wire                             s_axis_tvalid,
  output logic                            s_axis_tready,
  input  wire  [7:0]                      s_axis_tdata,   // [7:0] byte_value
  input  wire  [1:0]                      s_axis_tuser,   // [1:0] action
  // master side
  output logic                            m_axis_tvalid,
  input  wire                             m_axis_tready,
  output logic [31:0]                     m_axis_tdata,   // [7:0] tx_byte, [23:8] flash_address,
                                                          // [31:24] flash_data
  output logic [1:0]                      m_axis_tuser,   // [1:0] kind
  // configuration
  input  wire                             cfg_we,
  input  wire  [sfl_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [sfl_pkg::CFG_W-1:0]       cfg_data
);
  import sfl_pkg::*;

  cfg_t    cfg;
  logic    in_fire;
  logic    advance;
  logic    res_valid;
  result_t res;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.timeout_ticks <= TIMEOUT_RST;
      cfg.flash_base    <= BASE_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_TIMEOUT: cfg.timeout_ticks <= cfg_data[TIMEOUT_W-1:0];
        CFG_BASE:    cfg.flash_base    <= cfg_data[ADDR_W-1:0];
        default: ;
      endcase
    end
  end

  // Flow control: output register frees up when empty or taken
  assign advance       = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = !res_valid || advance;
  assign in_fire       = s_axis_tvalid && s_axis_tready;

  sfl_frame_engine #(
    .BLOCK_SIZE (BLOCK_SIZE)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .in_fire   (in_fire),
    .in_action (s_axis_tuser),
    .in_byte   (s_axis_tdata),
    .cfg       (cfg),
    .advance   (advance),
    .res_valid (res_valid),
    .res       (res)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (advance) begin
      m_axis_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res_valid) begin
      m_axis_tdata <= {res.flash_data, res.flash_address, res.tx_byte};
      m_axis_tuser <= res.kind;
    end
  end

endmodule

`default_nettype wire

@@ rtl/core/sfl_core_checker.sv @@
`timescale 1ns / 1ps
`default_nettype none

module sfl_core_checker (
  input wire        clk,
  input wire        rst,
  input wire        m_axis_tvalid,
  input wire        m_axis_tready,
  input wire [31:0] m_axis_tdata,
  input wire [1:0]  m_axis_tuser
);
  import sfl_pkg::*;

  logic jumped;

  // Remember that a jump beat has gone out
  always_ff @(posedge clk) begin
    if (rst) begin
      jumped <= 1'b0;
    end else if (m_axis_tvalid && m_axis_tready && m_axis_tuser == KIND_JUMP) begin
      jumped <= 1'b1;
    end
  end

  // stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
    else $error("result beat changed while stalled");

  // kind is valid and unused fields of each kind are zero
  a_fields: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |->
      (m_axis_tuser == KIND_TX && m_axis_tdata[31:8] == 24'd0) ||
      (m_axis_tuser == KIND_WRITE && m_axis_tdata[7:0] == 8'd0) ||
      (m_axis_tuser == KIND_JUMP && m_axis_tdata == 32'd0))
    else $error("bad result kind or stray field bits");

  // transmitted bytes are protocol replies only
  a_reply: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tuser == KIND_TX |->
      m_axis_tdata[7:0] == REPLY_READY || m_axis_tdata[7:0] == REPLY_OK ||
      m_axis_tdata[7:0] == REPLY_ERR)
    else $error("unexpected transmit byte");

  // engine stays silent after handing over to the application
  a_halt: assert property (@(posedge clk) disable iff (rst)
    jumped |-> !m_axis_tvalid)
    else $error("result after jump to application");

endmodule

bind serial_flash_loader_core sfl_core_checker u_sfl_core_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
